// ----- rtl/seven_segment_serial_display_unit_defines.svh -----
// Assertion macros shared by the display unit checker.
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SSD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define SSD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ssd_pkg.sv -----
// Shared types, constants and the segment table of the display unit.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int FRAME_BITS = 16;
    localparam int BIT_W      = 4;
    localparam int VALUE_W    = 15;
    localparam int POINT_W    = 3;
    localparam int PADDR_W    = 3;

    localparam logic [DIG_W-1:0]   LAST_DIG   = DIG_W'(NUM_DIGITS - 1);
    localparam logic [BIT_W-1:0]   LAST_BIT   = BIT_W'(FRAME_BITS - 1);
    localparam logic [POINT_W-1:0] POINT_RST  = 3'd2;
    localparam logic [PADDR_W-1:0] ADDR_POINT = 3'd0;
    localparam logic [7:0]         SEG_BLANK  = 8'hFF;
    localparam logic [7:0]         POINT_MASK = 8'h7F;

    // Division by ten: q = (v * 52429) >> 19 is exact for v below 262149.
    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W     = VALUE_W + 16;
    localparam int          QUOT_W     = PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic data_bit;
        logic latch_after;
        logic last;
    } t_out_word;

    typedef logic [NUM_DIGITS-1:0][7:0] t_seg_set;

    function automatic logic [7:0] f_seg(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0: seg = 8'hC0;
            4'd1: seg = 8'hF9;
            4'd2: seg = 8'hA4;
            4'd3: seg = 8'hB0;
            4'd4: seg = 8'h99;
            4'd5: seg = 8'h92;
            4'd6: seg = 8'h82;
            4'd7: seg = 8'hF8;
            4'd8: seg = 8'h80;
            4'd9: seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ssd_fifo.sv -----
// Two-entry queue of segment sets between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module ssd_fifo
    import ssd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_seg_set i_wdata,
    output logic     o_full_n,
    input  logic     i_pop,
    output t_seg_set o_rdata,
    output logic     o_empty_n
);

    t_seg_set   r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_push;
    logic       n_pop;

    assign o_full_n  = (r_cnt != 2'd2);
    assign o_empty_n = (r_cnt != 2'd0);
    assign o_rdata   = r_mem[r_rp];
    assign n_push    = i_push && o_full_n;
    assign n_pop     = i_pop && o_empty_n;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) begin
                r_wp <= ~r_wp;
            end
            if (n_pop) begin
                r_rp <= ~r_rp;
            end
            case ({n_push, n_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ssd_front.sv -----
// Front part: takes a command word and builds the segment byte of every digit.
`timescale 1ns / 1ps
`default_nettype none
module ssd_front
    import ssd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_word           i_word,
    input  logic [POINT_W-1:0] i_point_digit,
    output logic               o_push,
    output t_seg_set           o_segs,
    input  logic               i_full_n
);

    typedef enum logic [2:0] {
        FE_IDLE  = 3'b001,
        FE_SPLIT = 3'b010,
        FE_PUSH  = 3'b100
    } t_fe_state;

    t_fe_state          r_state;
    logic [VALUE_W-1:0] r_val;
    logic               r_blank;
    logic [DIG_W-1:0]   r_cnt;
    t_seg_set           r_segs;

    logic               n_take;
    logic [DIG_W-1:0]   n_pos;
    logic [PROD_W-1:0]  n_prod;
    logic [QUOT_W-1:0]  n_quot;
    logic [VALUE_W-1:0] n_q10;
    logic [3:0]         n_digit;
    logic [7:0]         n_seg;

    assign o_ready = (r_state == FE_IDLE) || ((r_state == FE_PUSH) && i_full_n);
    assign n_take  = i_valid && o_ready;
    assign o_push  = (r_state == FE_PUSH);
    assign o_segs  = r_segs;

    // The units digit comes out first; it sits at the rightmost position.
    always_comb begin
        n_pos   = LAST_DIG - r_cnt;
        n_prod  = PROD_W'(r_val) * PROD_W'(RECIP_10);
        n_quot  = n_prod[PROD_W-1:RECIP_SHIFT];
        n_q10   = VALUE_W'({n_quot, 3'b000}) + VALUE_W'({n_quot, 1'b0});
        n_digit = 4'(r_val - n_q10);
        n_seg   = f_seg(n_digit);
        if (r_blank) begin
            n_seg = SEG_BLANK;
        end else if (i_point_digit == POINT_W'(n_pos)) begin
            n_seg = n_seg & POINT_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            r_val   <= i_word.value;
            r_blank <= i_word.func;
        end else if (r_state == FE_SPLIT) begin
            r_val         <= VALUE_W'(n_quot);
            r_segs[n_pos] <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                FE_IDLE: begin
                    if (n_take) begin
                        r_state <= FE_SPLIT;
                        r_cnt   <= '0;
                    end
                end
                FE_SPLIT: begin
                    if (r_cnt == LAST_DIG) begin
                        r_state <= FE_PUSH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                FE_PUSH: begin
                    if (n_take) begin
                        r_state <= FE_SPLIT;
                        r_cnt   <= '0;
                    end else if (i_full_n) begin
                        r_state <= FE_IDLE;
                    end
                end
                default: begin
                    r_state <= FE_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ssd_back.sv -----
// Back part: shifts out the frames of one segment set, one bit per word.
`timescale 1ns / 1ps
`default_nettype none
module ssd_back
    import ssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty_n,
    input  t_seg_set  i_segs,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic             r_active;
    t_seg_set         r_segs;
    logic [DIG_W-1:0] r_dig;
    logic [BIT_W-1:0] r_bit;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             n_adv;
    logic             n_end;
    logic [7:0]       n_cur;
    logic [2:0]       n_sel_idx;
    t_out_word        n_word;

    assign n_adv   = r_active && (!r_out_valid || i_ready);
    assign n_end   = n_adv && (r_dig == LAST_DIG) && (r_bit == LAST_BIT);
    assign o_pop   = i_empty_n && (!r_active || n_end);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // The segment byte goes first, then the select byte with one bit per digit.
    always_comb begin
        n_cur     = r_segs[r_dig];
        n_sel_idx = 3'(LAST_DIG - r_dig);
        if (r_bit[3]) begin
            n_word.data_bit = (~r_bit[2:0] == n_sel_idx);
        end else begin
            n_word.data_bit = n_cur[~r_bit[2:0]];
        end
        n_word.latch_after = (r_bit == LAST_BIT);
        n_word.last        = (r_dig == LAST_DIG) && (r_bit == LAST_BIT);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_segs <= i_segs;
        end
        if (n_adv) begin
            r_out <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_dig       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_active <= 1'b1;
                r_dig    <= '0;
                r_bit    <= '0;
            end else if (n_end) begin
                r_active <= 1'b0;
            end else if (n_adv) begin
                r_bit <= r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    r_dig <= r_dig + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/seven_segment_serial_display_unit.sv -----
// Top level of the serial seven-segment display unit with its register port.
// The input channel (i_in_valid, o_in_ready, i_in_word) takes one command word:
// func 0 shows the low four decimal digits of value, func 1 blanks the display.
// The output channel (o_out_valid, i_out_ready, o_out_word) gives one word per
// shift clock: the serial data bit, a latch strobe on the 16th bit of each
// digit frame and a last flag on the final bit of the run.
// Each command yields NUM_DIGITS * 16 = 64 output words, one per cycle while
// the receiver is ready; the one-bit-per-cycle serial shifter sets the
// sustained command rate. The front splits the value, one divide-by-ten step
// per digit, and hands the segment bytes to a two-entry queue; the back pops
// them and registers each output word. The front keeps taking commands while
// the back shifts, until the queue fills. When the receiver stalls, the output
// word holds and the shifter waits. Reset empties the queue, drops all words
// in flight and sets point_digit to 2. point_digit is at byte address 0 of the
// APB port; the user must write it only idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_serial_display_unit
    import ssd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [POINT_W-1:0] r_point_digit;
    logic               n_push;
    t_seg_set           n_wsegs;
    logic               n_full_n;
    logic               n_pop;
    t_seg_set           n_rsegs;
    logic               n_empty_n;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_POINT) ? {29'd0, r_point_digit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_digit <= POINT_RST;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_POINT)) begin
            r_point_digit <= pwdata[POINT_W-1:0];
        end
    end

    ssd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_word        (i_in_word),
        .i_point_digit (r_point_digit),
        .o_push        (n_push),
        .o_segs        (n_wsegs),
        .i_full_n      (n_full_n)
    );

    ssd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (n_push),
        .i_wdata   (n_wsegs),
        .o_full_n  (n_full_n),
        .i_pop     (n_pop),
        .o_rdata   (n_rsegs),
        .o_empty_n (n_empty_n)
    );

    ssd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty_n (n_empty_n),
        .i_segs    (n_rsegs),
        .o_pop     (n_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_word    (o_out_word)
    );

endmodule
`default_nettype wire

// ----- rtl/ssd_checker.sv -----
// Port-level checker of the display unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_serial_display_unit_defines.svh"
module ssd_checker
    import ssd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word,
    input logic      pready
);

    `SSD_ASSERT_IMP(a_last_has_latch, o_out_valid && o_out_word.last, o_out_word.latch_after, "last word without latch strobe")
    `SSD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "stalled output word changed")
    `SSD_ASSERT_IMP(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind seven_segment_serial_display_unit ssd_checker u_ssd_checker (.*);
`default_nettype wire

// ----- tb/tb_seven_segment_serial_display_unit.sv -----
// Self-checking testbench for the serial seven-segment display unit.
`timescale 1ns / 1ps
module tb_seven_segment_serial_display_unit;
    import ssd_pkg::*;

    localparam int DRAIN_CYCLES = NUM_DIGITS + 16;
    localparam int REPORT_LIMIT = 10;
    localparam logic FUNC_SHOW  = 1'b0;
    localparam logic FUNC_BLANK = 1'b1;
    localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };
    localparam logic [POINT_W-1:0] POINT_PLAN [8] = '{
        3'd0, 3'd4, 3'd1, 3'd3, 3'd7, 3'd5, 3'd6, 3'd2
    };
    localparam int DIRECTED_SHOWS [15] = '{
        0, 32767, 9999, 10000, 1234, 5678, 9090, 1, 16384, 21845, 10922, 8888, 9, 99, 999
    };

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_word           in_word   = '0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    t_out_word          o_out_word;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    t_in_word           command_queue [$];
    t_out_word          expected_bits [$];
    logic [POINT_W-1:0] shown_point    = POINT_RST;
    int                 mismatch_count = 0;
    int                 send_gap       = 0;
    int                 recv_stall     = 0;

    seven_segment_serial_display_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Appends the serial bits of one command, frame by frame, MSB first.
    function automatic void serialize_command(input t_in_word cmd);
        int         divisor;
        logic [7:0] seg;
        logic [7:0] sel;
        logic [15:0] frame;
        t_out_word  bit_word;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            divisor = 1;
            for (int p = k + 1; p < NUM_DIGITS; p++) divisor *= 10;
            sel = 8'(1 << (NUM_DIGITS - 1 - k));
            if (cmd.func == FUNC_BLANK) begin
                seg = SEG_BLANK;
            end else begin
                seg = DIGIT_SEGMENTS[(int'(cmd.value) / divisor) % 10];
                if (shown_point == POINT_W'(k)) seg = seg & POINT_MASK;
            end
            frame = {seg, sel};
            for (int b = 0; b < FRAME_BITS; b++) begin
                bit_word.data_bit    = frame[FRAME_BITS - 1 - b];
                bit_word.latch_after = (b == FRAME_BITS - 1);
                bit_word.last        = (k == NUM_DIGITS - 1) && (b == FRAME_BITS - 1);
                expected_bits.push_back(bit_word);
            end
        end
    endfunction

    function automatic t_in_word make_command(input logic func, input int value);
        t_in_word cmd;
        cmd.func  = func;
        cmd.value = VALUE_W'(value);
        return cmd;
    endfunction

    function automatic t_in_word random_command();
        logic func;
        int   value;
        func = ($urandom_range(0, 99) < 15) ? FUNC_BLANK : FUNC_SHOW;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: value = $urandom_range(0, 32767);
            5, 6:          value = $urandom_range(0, 9999);
            7:             value = $urandom_range(0, 99);
            8: begin
                case ($urandom_range(0, 6))
                    0: value = 0;
                    1: value = 9;
                    2: value = 99;
                    3: value = 999;
                    4: value = 9999;
                    5: value = 10000;
                    default: value = 32767;
                endcase
            end
            default:       value = $urandom_range(10000, 32767);
        endcase
        return make_command(func, value);
    endfunction

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        if (roll < 96) return $urandom_range(5, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic int receiver_stall();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && o_in_ready) serialize_command(in_word);
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    in_word  <= command_queue.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= sender_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_bits.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected word data_bit=%0b latch_after=%0b last=%0b",
                        o_out_word.data_bit, o_out_word.latch_after, o_out_word.last));
                end else begin
                    want = expected_bits.pop_front();
                    if (o_out_word.data_bit !== want.data_bit ||
                        o_out_word.latch_after !== want.latch_after ||
                        o_out_word.last !== want.last) begin
                        report_mismatch($sformatf(
                            "expected data_bit=%0b latch_after=%0b last=%0b, got %0b %0b %0b",
                            want.data_bit, want.latch_after, want.last,
                            o_out_word.data_bit, o_out_word.latch_after, o_out_word.last));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready  <= 1'b1;
                recv_stall <= receiver_stall();
            end
        end
    end

    task automatic apb_access(input logic is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_POINT;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_point(input logic [POINT_W-1:0] point);
        logic [31:0] wdata;
        logic [31:0] readback;
        wdata = $urandom();
        wdata[POINT_W-1:0] = point;
        apb_access(1'b1, wdata, readback);
        shown_point = point;
        apb_access(1'b0, 32'd0, readback);
        if (readback[POINT_W-1:0] !== point) begin
            report_mismatch($sformatf("point_digit read expected %0d, got %0d",
                                      point, readback[POINT_W-1:0]));
        end
    endtask

    task automatic queue_random(input int count);
        @(negedge i_clk);
        repeat (count) command_queue.push_back(random_command());
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (command_queue.size() != 0 || in_valid || expected_bits.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] readback;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_access(1'b0, 32'd0, readback);
        if (readback[POINT_W-1:0] !== POINT_RST) begin
            report_mismatch($sformatf("point_digit after reset expected %0d, got %0d",
                                      POINT_RST, readback[POINT_W-1:0]));
        end
        @(negedge i_clk);
        foreach (DIRECTED_SHOWS[i]) begin
            command_queue.push_back(make_command(FUNC_SHOW, DIRECTED_SHOWS[i]));
        end
        command_queue.push_back(make_command(FUNC_BLANK, 0));
        command_queue.push_back(make_command(FUNC_BLANK, 32767));
        queue_random(20);
        wait_idle();
        foreach (POINT_PLAN[i]) begin
            set_point(POINT_PLAN[i]);
            queue_random(42);
            wait_idle();
        end
        set_point(POINT_W'($urandom_range(0, 7)));
        queue_random(45);
        wait_idle();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_fifo.sv
rtl/ssd_front.sv
rtl/ssd_back.sv
rtl/seven_segment_serial_display_unit.sv
rtl/ssd_checker.sv
tb/tb_seven_segment_serial_display_unit.sv
